>>> sv/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

    // Pipeline geometry
    localparam int DIV_BITS   = 32;
    localparam int ST_DIV1_IN = 1;                        // loads divider 1
    localparam int ST_DIV1_Q  = ST_DIV1_IN + DIV_BITS + 1; // first stage after it
    localparam int ST_DIV2_IN = ST_DIV1_Q + 6;            // loads divider 2
    localparam int ST_DIV2_Q  = ST_DIV2_IN + DIV_BITS + 1;
    localparam int NUM_STAGES = ST_DIV2_Q + 2;
    localparam int LAST       = NUM_STAGES - 1;

    // Register map
    localparam int ADDR_W = 5;
    typedef enum logic [2:0] {
        REG_CAL_A = 3'd0,
        REG_CAL_B = 3'd1,
        REG_CAL_C = 3'd2,
        REG_CAL_D = 3'd3,
        REG_CAL_E = 3'd4,
        REG_OSS   = 3'd5
    } reg_idx_t;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_BAD_OSS = 2'd1,
        STS_DIV0    = 2'd2
    } status_t;

    localparam logic [1:0] OSS_RESET = 2'd1;

    // Everything one item carries down the pipeline
    typedef struct packed {
        logic [15:0] ut;
        logic [18:0] up;
        logic [1:0]  oss;
        status_t     status;
        logic [31:0] prod;
        logic [31:0] x1;
        logic        neg;
        logic [31:0] div_n;
        logic [31:0] div_r;
        logic [31:0] div_d;
        logic [15:0] t;
        logic [31:0] b6;
        logic [31:0] sq;
        logic [31:0] pa2;
        logic [31:0] pa3;
        logic [31:0] mb2;
        logic [31:0] mb1;
        logic [31:0] b3;
        logic [31:0] v;
        logic [16:0] b4;
        logic [31:0] diff;
        logic        shl;
        logic [31:0] p;
        logic [31:0] xa2;
        logic [31:0] xb;
        logic [19:0] pres;
    } item_t;

    // One restoring division step: shift in the next dividend bit
    function automatic item_t div_step(item_t it);
        logic [32:0] r2;
        logic        ge;
        item_t       o;
        o  = it;
        r2 = {it.div_r, it.div_n[31]};
        ge = (r2 >= {1'b0, it.div_d});
        o.div_r = ge ? 32'(r2 - {1'b0, it.div_d}) : r2[31:0];
        o.div_n = {it.div_n[30:0], ge};
        return o;
    endfunction

endpackage

>>> sv/barometer_temp_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// barometer_temp_pressure_compensation_top
// Integer temperature/pressure compensation from raw sensor words, fully
// pipelined with two bit-per-stage dividers.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports
// s_       in         s_valid, s_ready, s_raw_temperature, s_raw_pressure
// m_       out        m_valid, m_ready, m_temperature_tenths, m_pressure_pa,
//                     m_status
// apb      in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One beat enters per cycle while the output is not stalled; most of the depth
// is the two 32-stage dividers (temperature x2 term and pressure quotient).
// Synchronous active-low reset clears the valid bits and the calibration registers and sets OSS to OSS_RESET.
// A stalled output freezes the whole pipeline; s_ready drops with it.
// ----------------------------------------------------------------------------
module barometer_temp_pressure_compensation_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [15:0]                 s_raw_temperature,
    input  logic [18:0]                 s_raw_pressure,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [15:0]          m_temperature_tenths,
    output logic [19:0]                 m_pressure_pa,
    output logic [1:0]                  m_status,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bptc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int NST = bptc_pkg::NUM_STAGES;

    logic [31:0] cal_a_reg, cal_b_reg, cal_c_reg, cal_d_reg, cal_e_reg;
    logic [1:0]  oss_reg;
    bptc_pkg::reg_idx_t widx;

    bptc_pkg::item_t st_reg  [NST];
    bptc_pkg::item_t st_next [NST];
    logic [NST-1:0]  valid_reg;
    logic            en;

    // Coefficients
    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;
    assign ac1 = cal_a_reg[31:16];
    assign ac2 = cal_a_reg[15:0];
    assign ac3 = cal_b_reg[31:16];
    assign ac4 = cal_b_reg[15:0];
    assign ac5 = cal_c_reg[31:16];
    assign ac6 = cal_c_reg[15:0];
    assign b1  = cal_d_reg[31:16];
    assign b2  = cal_d_reg[15:0];
    assign mc  = cal_e_reg[31:16];
    assign md  = cal_e_reg[15:0];

    // Configuration port
    assign pready = 1'b1;
    assign widx   = bptc_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            cal_d_reg <= '0;
            cal_e_reg <= '0;
            oss_reg   <= bptc_pkg::OSS_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (widx)
                bptc_pkg::REG_CAL_A: cal_a_reg <= pwdata;
                bptc_pkg::REG_CAL_B: cal_b_reg <= pwdata;
                bptc_pkg::REG_CAL_C: cal_c_reg <= pwdata;
                bptc_pkg::REG_CAL_D: cal_d_reg <= pwdata;
                bptc_pkg::REG_CAL_E: cal_e_reg <= pwdata;
                bptc_pkg::REG_OSS:   oss_reg   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            bptc_pkg::REG_CAL_A: prdata = cal_a_reg;
            bptc_pkg::REG_CAL_B: prdata = cal_b_reg;
            bptc_pkg::REG_CAL_C: prdata = cal_c_reg;
            bptc_pkg::REG_CAL_D: prdata = cal_d_reg;
            bptc_pkg::REG_CAL_E: prdata = cal_e_reg;
            bptc_pkg::REG_OSS:   prdata = {30'd0, oss_reg};
            default:             prdata = '0;
        endcase
    end

    // Advance the whole pipeline unless the output beat is held
    assign en      = !valid_reg[NST-1] || m_ready;
    assign s_ready = en;

    // Stage 0: capture and form (ut - ac6) * ac5
    always_comb begin
        logic signed [16:0] d17;
        logic signed [33:0] p34;
        st_next[0]     = st_reg[0];
        d17            = $signed({1'b0, s_raw_temperature}) - $signed({1'b0, ac6});
        p34            = d17 * $signed({1'b0, ac5});
        st_next[0].ut  = s_raw_temperature;
        st_next[0].up  = s_raw_pressure;
        st_next[0].oss = oss_reg;
        st_next[0].prod   = p34[31:0];
        st_next[0].status = (oss_reg == 2'd0) ? bptc_pkg::STS_BAD_OSS : bptc_pkg::STS_OK;
    end

    // Stage 1: x1, denominator, load divider 1 with magnitudes
    always_comb begin
        logic signed [31:0] x1, den, num;
        bptc_pkg::item_t    it;
        it  = st_reg[0];
        x1  = $signed(it.prod) >>> 15;
        den = x1 + 32'($signed(md));
        num = {{5{mc[15]}}, mc, 11'd0};
        it.x1    = x1;
        it.neg   = num[31] ^ den[31];
        it.div_n = num[31] ? 32'(-num) : num;
        it.div_d = den[31] ? 32'(-den) : den;
        it.div_r = '0;
        if (den == 32'sd0 && it.status == bptc_pkg::STS_OK) begin
            it.status = bptc_pkg::STS_DIV0;
        end
        st_next[bptc_pkg::ST_DIV1_IN] = it;
    end

    // Divider 1 and divider 2: one quotient bit per stage
    for (genvar k = 0; k < bptc_pkg::DIV_BITS; k++) begin : g_div
        always_comb begin
            st_next[bptc_pkg::ST_DIV1_IN + 1 + k] =
                bptc_pkg::div_step(st_reg[bptc_pkg::ST_DIV1_IN + k]);
            st_next[bptc_pkg::ST_DIV2_IN + 1 + k] =
                bptc_pkg::div_step(st_reg[bptc_pkg::ST_DIV2_IN + k]);
        end
    end

    // b5, temperature, b6
    always_comb begin
        logic signed [31:0] x2, b5, tt;
        bptc_pkg::item_t    it;
        it = st_reg[bptc_pkg::ST_DIV1_Q - 1];
        x2 = it.neg ? 32'(-it.div_n) : it.div_n;
        b5 = $signed(it.x1) + x2;
        tt = (b5 + 32'sd8) >>> 4;
        priority if (tt > 32'sd32767)       it.t = 16'h7FFF;
        else if (tt < -32'sd32768)          it.t = 16'h8000;
        else                                it.t = tt[15:0];
        it.b6 = 32'(b5 - 32'sd4000);
        st_next[bptc_pkg::ST_DIV1_Q] = it;
    end

    // b6 squared and linear products
    always_comb begin
        logic signed [63:0] m64;
        logic signed [47:0] m2, m3;
        bptc_pkg::item_t    it;
        it  = st_reg[bptc_pkg::ST_DIV1_Q];
        m64 = $signed(it.b6) * $signed(it.b6);
        m2  = ac2 * $signed(it.b6);
        m3  = ac3 * $signed(it.b6);
        it.sq  = $signed(m64[31:0]) >>> 12;
        it.pa2 = m2[31:0];
        it.pa3 = m3[31:0];
        st_next[bptc_pkg::ST_DIV1_Q + 1] = it;
    end

    // Quadratic products
    always_comb begin
        logic signed [47:0] m1, m2;
        bptc_pkg::item_t    it;
        it = st_reg[bptc_pkg::ST_DIV1_Q + 1];
        m2 = b2 * $signed(it.sq);
        m1 = b1 * $signed(it.sq);
        it.mb2 = m2[31:0];
        it.mb1 = m1[31:0];
        st_next[bptc_pkg::ST_DIV1_Q + 2] = it;
    end

    // b3 and the b4 multiplicand
    always_comb begin
        logic signed [31:0] x1, x2, x3, s, s2, y1, y2, y3;
        bptc_pkg::item_t    it;
        it = st_reg[bptc_pkg::ST_DIV1_Q + 2];
        x1 = $signed(it.mb2) >>> 11;
        x2 = $signed(it.pa2) >>> 11;
        x3 = x1 + x2;
        s  = {{14{ac1[15]}}, ac1, 2'b00} + x3;
        s2 = s <<< it.oss;
        it.b3 = (s2 + 32'sd2) >>> 2;
        y1 = $signed(it.pa3) >>> 13;
        y2 = $signed(it.mb1) >>> 16;
        y3 = (y1 + y2 + 32'sd2) >>> 2;
        it.v = 32'(y3 + 32'sd32768);
        st_next[bptc_pkg::ST_DIV1_Q + 3] = it;
    end

    // b4 and up - b3
    always_comb begin
        logic [47:0]     m;
        bptc_pkg::item_t it;
        it = st_reg[bptc_pkg::ST_DIV1_Q + 3];
        m  = ac4 * it.v;
        it.b4   = m[31:15];
        it.diff = 32'({13'd0, it.up} - it.b3);
        if (m[31:15] == 17'd0 && it.status == bptc_pkg::STS_OK) begin
            it.status = bptc_pkg::STS_DIV0;
        end
        st_next[bptc_pkg::ST_DIV1_Q + 4] = it;
    end

    // b7
    always_comb begin
        logic [15:0]     k;
        logic [47:0]     m;
        bptc_pkg::item_t it;
        it = st_reg[bptc_pkg::ST_DIV1_Q + 4];
        k  = 16'(16'd50000 >> it.oss);
        m  = it.diff * k;
        it.p = m[31:0];
        st_next[bptc_pkg::ST_DIV1_Q + 5] = it;
    end

    // Load divider 2: shift before dividing unless the top bit is set
    always_comb begin
        bptc_pkg::item_t it;
        it = st_reg[bptc_pkg::ST_DIV2_IN - 1];
        it.shl   = it.p[31];
        it.div_n = it.p[31] ? it.p : {it.p[30:0], 1'b0};
        it.div_d = {15'd0, it.b4};
        it.div_r = '0;
        st_next[bptc_pkg::ST_DIV2_IN] = it;
    end

    // Pressure correction products
    always_comb begin
        logic signed [31:0] p, xa;
        logic signed [63:0] m1;
        logic signed [47:0] m2;
        bptc_pkg::item_t    it;
        it = st_reg[bptc_pkg::ST_DIV2_Q - 1];
        p  = it.shl ? {it.div_n[30:0], 1'b0} : it.div_n;
        xa = p >>> 8;
        m1 = xa * xa;
        m2 = -16'sd7357 * p;
        it.p   = p;
        it.xa2 = m1[31:0];
        it.xb  = m2[31:0];
        st_next[bptc_pkg::ST_DIV2_Q] = it;
    end

    // Final correction, saturation and error zeroing
    always_comb begin
        logic signed [45:0] m;
        logic signed [31:0] c, d, e, p2;
        bptc_pkg::item_t    it;
        it = st_reg[bptc_pkg::ST_DIV2_Q];
        m  = $signed(it.xa2) * 14'sd3038;
        c  = $signed(m[31:0]) >>> 16;
        d  = $signed(it.xb) >>> 16;
        e  = (c + d + 32'sd3791) >>> 4;
        p2 = $signed(it.p) + e;
        priority if (p2 < 32'sd0)        it.pres = '0;
        else if (p2 > 32'sd1048575)      it.pres = 20'hFFFFF;
        else                             it.pres = p2[19:0];
        if (it.status != bptc_pkg::STS_OK) begin
            it.pres = '0;
            it.t    = '0;
        end
        st_next[bptc_pkg::LAST] = it;
    end

    // Pipeline registers: valid bits reset, payload does not
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NST-2:0], s_valid};
        end
    end

    for (genvar i = 0; i < NST; i++) begin : g_st
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign m_valid              = valid_reg[NST-1];
    assign m_temperature_tenths = st_reg[NST-1].t;
    assign m_pressure_pa        = st_reg[NST-1].pres;
    assign m_status             = st_reg[NST-1].status;

    // Error results carry zero fields
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != bptc_pkg::STS_OK) |->
            (m_temperature_tenths == 16'sd0) && (m_pressure_pa == 20'd0))
        else $error("error result with nonzero fields");

    // A held output beat stops intake
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while output stalled");

    // Status code never takes the unused value
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == bptc_pkg::STS_OK) || (m_status == bptc_pkg::STS_BAD_OSS)
            || (m_status == bptc_pkg::STS_DIV0))
        else $error("bad status code");

endmodule
